>>> design/u16u8_pkg.sv
// u16u8_pkg: shared types, constants and byte-encoding functions for the
// utf-16 to utf-8 encoder; no dependencies
`timescale 1ns / 1ps

package u16u8_pkg;

	localparam logic [15:0] HIGH_FIRST = 16'hD800;
	localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
	localparam logic [15:0] LOW_FIRST  = 16'hDC00;
	localparam logic [15:0] LOW_LAST   = 16'hDFFF;
	localparam logic [15:0] CAP_RESET  = 16'hFFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam int unsigned MAX_DATA   = 6;

	// per-string state
	typedef struct packed {
		logic [9:0]  held_high;
		logic        held_valid;
		logic [15:0] bytes_written;
		logic        overflowed;
	} str_state_t;

	// all results of one word: data bytes followed by an optional terminator
	typedef struct packed {
		logic [MAX_DATA-1:0][7:0] data;
		logic [2:0]               nbytes;
		logic                     has_term;
		logic                     term_full;
		logic [15:0]              term_count;
	} burst_t;

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		logic [2:0] n;
		if (cp < 21'h80) begin
			n = 3'd1;
		end else if (cp < 21'h800) begin
			n = 3'd2;
		end else if (cp < 21'h10000) begin
			n = 3'd3;
		end else begin
			n = 3'd4;
		end
		return n;
	endfunction

	// byte 0 is sent first
	function automatic logic [3:0][7:0] utf8_enc(input logic [20:0] cp);
		logic [3:0][7:0] b;
		b = '0;
		case (utf8_len(cp))
			3'd1: begin
				b[0] = {1'b0, cp[6:0]};
			end
			3'd2: begin
				b[0] = {3'b110, cp[10:6]};
				b[1] = {2'b10, cp[5:0]};
			end
			3'd3: begin
				b[0] = {4'b1110, cp[15:12]};
				b[1] = {2'b10, cp[11:6]};
				b[2] = {2'b10, cp[5:0]};
			end
			default: begin
				b[0] = {5'b11110, cp[20:18]};
				b[1] = {2'b10, cp[17:12]};
				b[2] = {2'b10, cp[11:6]};
				b[3] = {2'b10, cp[5:0]};
			end
		endcase
		return b;
	endfunction

endpackage

>>> design/u16u8_if.sv
// u16u8_if: valid/ready channel interfaces for input words, output bytes
// and the capacity write port; depends on nothing
`timescale 1ns / 1ps

interface u16u8_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_string;
	modport source (output valid, code_unit, end_of_string, input ready);
	modport sink (input valid, code_unit, end_of_string, output ready);
endinterface

interface u16u8_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_terminator;
	logic        last;
	logic        buffer_full;
	logic [15:0] byte_count;
	modport source (output valid, out_byte, is_terminator, last, buffer_full, byte_count,
		input ready);
	modport sink (input valid, out_byte, is_terminator, last, buffer_full, byte_count,
		output ready);
endinterface

interface u16u8_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> design/u16u8_encode.sv
// u16u8_encode: combinational step from one code unit and the string state
// to the burst of result bytes and the next state; uses u16u8_pkg
`timescale 1ns / 1ps

module u16u8_encode (
	input  u16u8_pkg::str_state_t st,
	input  logic [15:0]           code_unit,
	input  logic                  end_of_string,
	input  logic [15:0]           dest_capacity,
	output u16u8_pkg::burst_t     burst,
	output u16u8_pkg::str_state_t nxt
);

	logic            is_high, is_low, hold_new;
	logic            c1_en, c2_en, fit1, fit2, ok;
	logic [20:0]     c1_cp, c2_cp;
	logic [2:0]      n1, n2, e1, e2;
	logic [15:0]     bw1, bw_final;
	logic [3:0][7:0] b1, b2;
	logic [2:0]      j;

	assign is_high = (code_unit >= u16u8_pkg::HIGH_FIRST) && (code_unit <= u16u8_pkg::HIGH_LAST);
	assign is_low  = (code_unit >= u16u8_pkg::LOW_FIRST) && (code_unit <= u16u8_pkg::LOW_LAST);
	assign hold_new = is_high && !end_of_string;

	always_comb begin
		if (st.held_valid && is_low) begin
			// surrogate pair
			c1_en = 1'b1;
			c1_cp = u16u8_pkg::SUPP_BASE + 21'({st.held_high, code_unit[9:0]});
			c2_en = 1'b0;
		end else begin
			// lone held high surrogate goes out first in its 3-byte form
			c1_en = st.held_valid;
			c1_cp = 21'({6'b110110, st.held_high});
			c2_en = !hold_new;
		end
		c2_cp = 21'(code_unit);
	end

	assign n1 = u16u8_pkg::utf8_len(c1_cp);
	assign n2 = u16u8_pkg::utf8_len(c2_cp);
	assign b1 = u16u8_pkg::utf8_enc(c1_cp);
	assign b2 = u16u8_pkg::utf8_enc(c2_cp);

	// room must remain for the terminator
	assign fit1 = !c1_en || (({1'b0, st.bytes_written} + 17'(n1)) < {1'b0, dest_capacity});
	assign e1   = (c1_en && fit1) ? n1 : 3'd0;
	assign bw1  = st.bytes_written + 16'(e1);
	assign fit2 = !c2_en || (({1'b0, bw1} + 17'(n2)) < {1'b0, dest_capacity});
	assign ok   = fit1 && fit2;
	assign e2   = (fit1 && c2_en && fit2) ? n2 : 3'd0;
	assign bw_final = bw1 + 16'(e2);

	always_comb begin
		burst = '0;
		nxt   = st;
		j     = '0;
		for (int i = 0; i < u16u8_pkg::MAX_DATA; i++) begin
			if (3'(i) < e1) begin
				burst.data[i] = b1[2'(i)];
			end else begin
				j = 3'(i) - e1;
				burst.data[i] = b2[j[1:0]];
			end
		end
		if (st.overflowed) begin
			// skipping the rest of a cut string
			burst.nbytes = 3'd0;
			if (end_of_string) begin
				nxt = '0;
			end
		end else if (!ok) begin
			burst.nbytes    = e1 + e2;
			burst.has_term  = 1'b1;
			burst.term_full = 1'b1;
			nxt            = '0;
			nxt.overflowed = !end_of_string;
		end else if (end_of_string) begin
			burst.nbytes     = e1 + e2;
			burst.has_term   = 1'b1;
			burst.term_count = bw_final;
			nxt = '0;
		end else begin
			burst.nbytes      = e1 + e2;
			nxt.bytes_written = bw_final;
			nxt.held_valid    = hold_new;
			if (hold_new) begin
				nxt.held_high = code_unit[9:0];
			end
		end
	end

endmodule

>>> design/utf16_to_utf8_encoder_unit.sv
// utf16_to_utf8_encoder_unit: top level of the utf-16 to utf-8 encoder, built on
// u16u8_pkg, u16u8_if and u16u8_encode
// a word is registered in the input stage at acceptance and encoded into the burst
// register when the burst stage is free; dst offers its bytes from that register
// throughput: one byte per cycle on dst while dst.ready is high; a word gives 1 to 7
// results or none; reset (arst_n low, async): state cleared, capacity 65535
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_unit (
	input logic         clk,
	input logic         arst_n,
	u16u8_in_if.sink    src,
	u16u8_out_if.source dst,
	u16u8_cfg_if.sink   cfg
);

	// capacity register, always writable
	logic [15:0] dest_capacity_q;

	// input stage
	logic        valid_s1;
	logic [15:0] code_unit_s1;
	logic        eos_s1;

	// burst stage feeding the byte serializer
	logic                  valid_s2;
	u16u8_pkg::burst_t     burst_s2;
	logic [2:0]            idx_q;

	u16u8_pkg::str_state_t st_q;
	u16u8_pkg::str_state_t st_nxt;
	u16u8_pkg::burst_t     burst_nxt;

	logic       out_fire, burst_done, s2_free, s1_adv, has_res;
	logic [2:0] total;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_capacity_q <= u16u8_pkg::CAP_RESET;
		end else if (cfg.valid) begin
			dest_capacity_q <= cfg.data;
		end
	end

	u16u8_encode u_encode (
		.st            (st_q),
		.code_unit     (code_unit_s1),
		.end_of_string (eos_s1),
		.dest_capacity (dest_capacity_q),
		.burst         (burst_nxt),
		.nxt           (st_nxt)
	);

	// total results in the held burst, terminator included
	assign total      = burst_s2.nbytes + 3'(burst_s2.has_term);
	assign out_fire   = dst.valid && dst.ready;
	assign burst_done = out_fire && (idx_q == total - 3'd1);
	assign s2_free    = !valid_s2 || burst_done;
	assign has_res    = (burst_nxt.nbytes != 3'd0) || burst_nxt.has_term;
	// a word with no results retires without waiting for the burst stage
	assign s1_adv     = valid_s1 && (!has_res || s2_free);
	assign src.ready  = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.ready && src.valid) begin
			code_unit_s1 <= src.code_unit;
			eos_s1       <= src.end_of_string;
		end
	end

	// string state moves only when a word retires from the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (s1_adv) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && has_res;
			idx_q    <= '0;
		end else if (out_fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && has_res) begin
			burst_s2 <= burst_nxt;
		end
	end

	// byte select: data bytes first, then the terminator
	always_comb begin
		dst.valid         = valid_s2;
		dst.last          = (idx_q == total - 3'd1);
		if (idx_q < burst_s2.nbytes) begin
			dst.out_byte      = burst_s2.data[idx_q];
			dst.is_terminator = 1'b0;
			dst.buffer_full   = 1'b0;
			dst.byte_count    = '0;
		end else begin
			dst.out_byte      = '0;
			dst.is_terminator = 1'b1;
			dst.buffer_full   = burst_s2.term_full;
			dst.byte_count    = burst_s2.term_count;
		end
	end

endmodule

>>> design/u16u8_check.sv
// u16u8_check: port-level assertions for utf16_to_utf8_encoder_unit and the
// bind that attaches them; depends on the top level
`timescale 1ns / 1ps

module u16u8_check (
	input logic        clk,
	input logic        arst_n,
	input logic        dst_valid,
	input logic        dst_ready,
	input logic [7:0]  dst_out_byte,
	input logic        dst_is_terminator,
	input logic        dst_last,
	input logic        dst_buffer_full,
	input logic [15:0] dst_byte_count
);

	// a stalled byte stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid)
		else $error("output word dropped while stalled");

	// the terminator closes its word
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_is_terminator |-> dst_last && (dst_out_byte == 8'h00))
		else $error("terminator not last or not zero");

	// data bytes carry no status
	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_is_terminator |-> !dst_buffer_full && (dst_byte_count == 16'h0000))
		else $error("data byte carries terminator status");

	// an error terminator reports no count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_buffer_full |-> dst_is_terminator && (dst_byte_count == 16'h0000))
		else $error("error terminator with nonzero count");

	// after a terminator is taken the next byte starts a fresh string,
	// so a continuation byte cannot directly follow
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_ready && dst_is_terminator ##1 dst_valid && !dst_is_terminator
		|-> (dst_out_byte[7:6] != 2'b10))
		else $error("continuation byte at start of string");

endmodule

bind utf16_to_utf8_encoder_unit u16u8_check u_check (
	.clk               (clk),
	.arst_n            (arst_n),
	.dst_valid         (dst.valid),
	.dst_ready         (dst.ready),
	.dst_out_byte      (dst.out_byte),
	.dst_is_terminator (dst.is_terminator),
	.dst_last          (dst.last),
	.dst_buffer_full   (dst.buffer_full),
	.dst_byte_count    (dst.byte_count)
);

>>> dv/tb_top.sv
// tb_top: self-checking bench for utf16_to_utf8_encoder_unit, with a utf-8 byte predictor,
// random handshake idling and capacity phases
// depends on u16u8_pkg, u16u8_if and the encoder rtl
`timescale 1ns / 1ps

module tb_top;

	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN      = 10;

	// one expected or observed byte word on the output channel
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_terminator;
		logic        last;
		logic        buffer_full;
		logic [15:0] byte_count;
	} utf8_byte_t;

	// shapes of random code units inside a string
	typedef enum {
		CH_ASCII, CH_TWO_BYTE, CH_THREE_BYTE, CH_PAIR, CH_LONE_HIGH, CH_LONE_LOW, CH_NOISE
	} char_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	u16u8_in_if  src_if ();
	u16u8_out_if dst_if ();
	u16u8_cfg_if cfg_if ();

	utf16_to_utf8_encoder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.src    (src_if),
		.dst    (dst_if),
		.cfg    (cfg_if)
	);

	always #2 clk = ~clk;

	// predictor copy of the encoder state and its capacity register
	logic [15:0] cap_reg;
	logic [9:0]  pend_high;
	logic        pend_valid;
	logic [15:0] str_bytes;
	logic        str_cut;

	utf8_byte_t expected_bytes[$];   // bytes still owed by the dut, oldest first
	utf8_byte_t word_bytes[$];       // bytes caused by the word being predicted
	utf8_byte_t got_byte;
	utf8_byte_t want_byte;

	int  fail_count;
	int  sent_words;                 // words handed to the encoder so far
	int  idle_cycles;
	bit  src_idle_on;
	bit  dst_idle_on;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------

	function automatic void restart_string();
		pend_high  = '0;
		pend_valid = 1'b0;
		str_bytes  = '0;
		str_cut    = 1'b0;
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic term, input logic full,
		input logic [15:0] cnt);
		utf8_byte_t r;
		r.out_byte      = b;
		r.is_terminator = term;
		r.last          = 1'b0;
		r.buffer_full   = full;
		r.byte_count    = cnt;
		word_bytes.push_back(r);
	endfunction

	// append the utf-8 form of one code point; 0 when it would not leave room
	// for the terminator
	function automatic bit encode_char(input logic [20:0] cp);
		int unsigned n;
		int          i;
		logic [7:0]  lead;
		n = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
		if (32'(str_bytes) + n >= 32'(cap_reg))
			return 1'b0;
		case (n)
			1: lead = cp[7:0];
			2: lead = 8'hC0 | 8'(cp >> 6);
			3: lead = 8'hE0 | 8'(cp >> 12);
			default: lead = 8'hF0 | 8'(cp >> 18);
		endcase
		add_byte(lead, 1'b0, 1'b0, 16'd0);
		// continuation bytes, most significant six bits first
		for (i = int'(n) - 2; i >= 0; i--)
			add_byte(8'h80 | 8'((cp >> (6 * i)) & 21'h3F), 1'b0, 1'b0, 16'd0);
		str_bytes = str_bytes + 16'(n);
		return 1'b1;
	endfunction

	// work out every byte one accepted word causes and queue them
	function automatic void predict_word(input logic [15:0] cu, input logic eos);
		bit         ok;
		bit         is_high;
		bit         is_low;
		utf8_byte_t one;
		ok = 1'b1;
		word_bytes.delete();
		is_high = (cu >= u16u8_pkg::HIGH_FIRST) && (cu <= u16u8_pkg::HIGH_LAST);
		is_low  = (cu >= u16u8_pkg::LOW_FIRST) && (cu <= u16u8_pkg::LOW_LAST);
		// a cut string swallows words up to its end marker
		if (str_cut) begin
			if (eos)
				restart_string();
			return;
		end
		if (pend_valid && is_low) begin
			pend_valid = 1'b0;
			ok = encode_char(u16u8_pkg::SUPP_BASE + {1'b0, pend_high, cu[9:0]});
		end else begin
			// an unpaired high surrogate goes out in its 3-byte form first
			if (pend_valid) begin
				pend_valid = 1'b0;
				ok = encode_char({5'd0, u16u8_pkg::HIGH_FIRST | {6'd0, pend_high}});
			end
			if (ok) begin
				if (is_high && !eos) begin
					pend_high  = cu[9:0];
					pend_valid = 1'b1;
				end else begin
					ok = encode_char({5'd0, cu});
				end
			end
		end
		if (!ok) begin
			add_byte(8'h00, 1'b1, 1'b1, 16'd0);
			restart_string();
			str_cut = !eos;
		end else if (eos) begin
			add_byte(8'h00, 1'b1, 1'b0, str_bytes);
			restart_string();
		end
		while (word_bytes.size() > 0) begin
			one = word_bytes.pop_front();
			one.last = (word_bytes.size() == 0);
			expected_bytes.push_back(one);
		end
	endfunction

	function automatic string show_byte(input utf8_byte_t r);
		return $sformatf("byte %02h term %0b last %0b full %0b count %0d",
			r.out_byte, r.is_terminator, r.last, r.buffer_full, r.byte_count);
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// send one code unit word; valid stays high on return so back-to-back
	// words never drop it within one time step
	task automatic send_word(input logic [15:0] cu, input logic eos);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			src_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_word(cu, eos);
		sent_words++;
		src_if.valid         <= 1'b1;
		src_if.code_unit     <= cu;
		src_if.end_of_string <= eos;
		do @(posedge clk); while (src_if.ready !== 1'b1);
	endtask

	// stop sending, let every owed byte arrive, then give a word with no
	// result time to leave the pipeline
	task automatic wait_idle();
		src_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [15:0] cap);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= cap;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		cfg_if.valid <= 1'b0;
		cap_reg = cap;
	endtask

	// random string of well-formed and broken pieces; one in ten is left
	// open so the next string runs on into it
	task automatic send_random_string();
		int         len;
		int         i;
		logic       close;
		logic       eos;
		char_kind_t kind;
		len   = $urandom_range(1, 8);
		close = ($urandom_range(0, 9) != 0);
		for (i = 0; i < len; i++) begin
			eos = close && (i == len - 1);
			case ($urandom_range(0, 9))
				0, 1, 2: kind = CH_ASCII;
				3:       kind = CH_TWO_BYTE;
				4:       kind = CH_THREE_BYTE;
				5, 6:    kind = CH_PAIR;
				7:       kind = CH_LONE_HIGH;
				8:       kind = CH_LONE_LOW;
				default: kind = CH_NOISE;
			endcase
			case (kind)
				CH_ASCII: send_word(16'($urandom_range(0, 16'h7F)), eos);
				CH_TWO_BYTE: send_word(16'($urandom_range(16'h80, 16'h7FF)), eos);
				CH_THREE_BYTE: begin
					if ($urandom_range(0, 1))
						send_word(16'($urandom_range(16'h800, 16'hD7FF)), eos);
					else
						send_word(16'($urandom_range(16'hE000, 16'hFFFF)), eos);
				end
				CH_PAIR: begin
					send_word(u16u8_pkg::HIGH_FIRST + 16'($urandom_range(0, 1023)), 1'b0);
					send_word(u16u8_pkg::LOW_FIRST + 16'($urandom_range(0, 1023)), eos);
				end
				CH_LONE_HIGH:
					send_word(u16u8_pkg::HIGH_FIRST + 16'($urandom_range(0, 1023)), eos);
				CH_LONE_LOW:
					send_word(u16u8_pkg::LOW_FIRST + 16'($urandom_range(0, 1023)), eos);
				default: send_word(16'($urandom), eos);
			endcase
		end
	endtask

	// ------------------------------------------------------------------
	// byte receiver: random stall before each byte word
	// ------------------------------------------------------------------

	initial begin
		int stall;
		forever begin
			stall = dst_idle_on ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				dst_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			dst_if.ready <= 1'b1;
			do @(posedge clk); while (dst_if.valid !== 1'b1);
		end
	end

	// ------------------------------------------------------------------
	// checker: every accepted byte word against the oldest expectation
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (dst_if.valid === 1'b1 && dst_if.ready === 1'b1) begin
			got_byte.out_byte      = dst_if.out_byte;
			got_byte.is_terminator = dst_if.is_terminator;
			got_byte.last          = dst_if.last;
			got_byte.buffer_full   = dst_if.buffer_full;
			got_byte.byte_count    = dst_if.byte_count;
			if (expected_bytes.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("%0t unexpected word: %s", $realtime, show_byte(got_byte));
			end else begin
				want_byte = expected_bytes.pop_front();
				if (got_byte.out_byte !== want_byte.out_byte
					|| got_byte.is_terminator !== want_byte.is_terminator
					|| got_byte.last !== want_byte.last
					|| got_byte.buffer_full !== want_byte.buffer_full
					|| got_byte.byte_count !== want_byte.byte_count) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN)
						$display("%0t mismatch: expected %s, got %s", $realtime,
							show_byte(want_byte), show_byte(got_byte));
				end
			end
		end
	end

	// watchdog: too long with no word moving on any channel
	always @(posedge clk) begin
		if ((src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)
			|| (cfg_if.valid && cfg_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog expired, %0d bytes outstanding", $realtime,
				expected_bytes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// length boundaries of the 1, 2 and 3 byte forms at reset capacity
	task automatic test_encoding_ranges();
		src_idle_on = 1'b0;
		dst_idle_on = 1'b0;
		send_word(16'h0000, 1'b0);
		send_word(16'h007F, 1'b0);
		send_word(16'h0080, 1'b0);
		send_word(16'h07FF, 1'b0);
		send_word(16'h0800, 1'b0);
		send_word(16'hFFFF, 1'b1);
	endtask

	// pairs at both ends of the range, and every way a surrogate is left alone
	task automatic test_surrogates();
		src_idle_on = 1'b1;
		dst_idle_on = 1'b1;
		send_word(16'hD800, 1'b0);
		send_word(16'hDC00, 1'b0);
		send_word(16'hDBFF, 1'b0);
		send_word(16'hDFFF, 1'b0);
		// high followed by a plain character
		send_word(16'hD801, 1'b0);
		send_word(16'h0041, 1'b0);
		// low with nothing held
		send_word(16'hDC00, 1'b0);
		// high followed by another high, then a pair closing the string
		send_word(16'hD800, 1'b0);
		send_word(16'hDBFF, 1'b0);
		send_word(16'hDC01, 1'b1);
		// high on the end marker goes out as its 3-byte form
		send_word(16'hDBFF, 1'b1);
	endtask

	// capacity extremes: nothing fits, overflow mid-string and on the end word
	task automatic test_capacity_limits();
		src_idle_on = 1'b1;
		dst_idle_on = 1'b0;
		write_capacity(16'd0);
		send_word(16'h0041, 1'b1);
		// held high comes out, then the next character overflows
		write_capacity(16'd5);
		send_word(16'hD800, 1'b0);
		send_word(16'h0800, 1'b0);
		send_word(16'h0041, 1'b0);
		send_word(16'h0041, 1'b1);
		send_word(16'h0041, 1'b1);
		// a pair that does not fit on the end word
		write_capacity(16'd4);
		send_word(16'hD800, 1'b0);
		send_word(16'hDC00, 1'b1);
	endtask

	// random strings over several capacity settings, first phase without idling
	task automatic test_random_strings();
		logic [15:0] caps[6];
		int          p;
		int          phase_start;
		caps[0] = 16'hFFFF;
		caps[1] = 16'($urandom_range(1, 12));
		caps[2] = 16'h0000;
		caps[3] = 16'($urandom_range(13, 64));
		caps[4] = 16'($urandom);
		caps[5] = 16'($urandom_range(2, 8));
		for (p = 0; p < 6; p++) begin
			src_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
			dst_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
			write_capacity(caps[p]);
			phase_start = sent_words;
			while (sent_words - phase_start < 10)
				send_random_string();
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		src_if.valid         <= 1'b0;
		src_if.code_unit     <= '0;
		src_if.end_of_string <= 1'b0;
		cfg_if.valid         <= 1'b0;
		cfg_if.data          <= '0;
		fail_count  = 0;
		sent_words  = 0;
		idle_cycles = 0;
		src_idle_on = 1'b0;
		dst_idle_on = 1'b0;
		cap_reg     = u16u8_pkg::CAP_RESET;
		restart_string();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encoding_ranges();
		test_surrogates();
		test_capacity_limits();
		test_random_strings();

		// everything owed has to show up, and nothing more after it
		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> utf16_to_utf8_encoder_unit.f
design/u16u8_pkg.sv
design/u16u8_if.sv
design/u16u8_encode.sv
design/utf16_to_utf8_encoder_unit.sv
design/u16u8_check.sv
dv/tb_top.sv
